// ----- hdl/prt_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// prt_pkg
// shared constants and the control bundle broadcast to every table cell
// ----------------------------------------------------------------------------
package prt_pkg;

    localparam int MAX_AREAS_DEF = 8;
    localparam int MAX_AREAS_TOP = 64;
    localparam int IDX_W         = $clog2(MAX_AREAS_TOP + 1);
    localparam int ADDR_W        = 16;
    localparam int FUNC_W        = 2;
    localparam int HANDLE_W      = 4;

    localparam logic [FUNC_W-1:0] FN_ADD    = 2'd0;
    localparam logic [FUNC_W-1:0] FN_REMOVE = 2'd1;
    localparam logic [FUNC_W-1:0] FN_CHECK  = 2'd2;

    typedef struct packed {
        logic              act;
        logic              add;
        logic              shift;
        logic              check;
        logic [IDX_W-1:0]  count;
        logic [IDX_W-1:0]  first;
        logic [ADDR_W-1:0] lo;
        logic [ADDR_W-1:0] hi;
        logic [ADDR_W-1:0] addr;
    } t_cell_ctl;

endpackage

`default_nettype wire

// ----- hdl/prt_cell.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// prt_cell
// one table entry: loads on add, takes its neighbour's entry on remove,
// registers its own range hit on check
// ----------------------------------------------------------------------------
module prt_cell #(
    parameter int IDX       = 0,
    parameter int MAX_AREAS = 8
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  prt_pkg::t_cell_ctl             i_ctl,
    input  wire  [prt_pkg::ADDR_W-1:0]     i_nxt_lo,
    input  wire  [prt_pkg::ADDR_W-1:0]     i_nxt_hi,
    output logic [prt_pkg::ADDR_W-1:0]     o_lo,
    output logic [prt_pkg::ADDR_W-1:0]     o_hi,
    output logic                           o_hit
);
    import prt_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX   = IDX_W'(IDX);
    localparam bit               HAS_NEXT = (IDX + 1) < MAX_AREAS;

    logic [ADDR_W-1:0] r_lo, n_lo;
    logic [ADDR_W-1:0] r_hi, n_hi;
    logic              r_hit, n_hit;
    logic              w_valid;

    assign w_valid = MY_IDX < i_ctl.count;

    always_comb begin
        n_lo  = r_lo;
        n_hi  = r_hi;
        n_hit = r_hit;
        if (i_ctl.act) begin
            n_hit = i_ctl.check && w_valid &&
                    (i_ctl.addr >= r_lo) && (i_ctl.addr <= r_hi);
            if (i_ctl.add && (MY_IDX == i_ctl.count)) begin
                n_lo = i_ctl.lo;
                n_hi = i_ctl.hi;
            end else if (i_ctl.shift && HAS_NEXT && (MY_IDX >= i_ctl.first)) begin
                n_lo = i_nxt_lo;
                n_hi = i_nxt_hi;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo <= n_lo;
        r_hi <= n_hi;
        if (!i_rst_n) begin
            r_hit <= 1'b0;
        end else begin
            r_hit <= n_hit;
        end
    end

    assign o_lo  = r_lo;
    assign o_hi  = r_hi;
    assign o_hit = r_hit;

endmodule

`default_nettype wire

// ----- hdl/protected_range_table_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// protected_range_table_core
// table of inclusive address ranges held in a row of cells
// ----------------------------------------------------------------------------
// a result passes through the registered hit of each cell and then the reduction
// into the result register; a new item is taken only once the last one has been
// evaluated and the output register is empty or being read
// reset: clears the entry count and the handshake state, entries are
// left as they are, no clearing pass
module protected_range_table_core #(
    parameter int MAX_AREAS = prt_pkg::MAX_AREAS_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // range_start, range_end, handle_in, probe_address, zero pad
    input  wire  [55:0] s_axis_tdata,
    // func
    input  wire  [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // handle_out, remove_ok, in_zone, zero pad
    output logic [7:0]  m_axis_tdata
);
    import prt_pkg::*;

    localparam int CW = $clog2(MAX_AREAS + 1);
    localparam int XW = (CW > HANDLE_W) ? CW : HANDLE_W;
    localparam logic [XW-1:0] N_X = XW'(MAX_AREAS);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EVAL = 2'b10
    } t_state;

    t_state              r_state, n_state;
    logic [CW-1:0]       r_count, n_count;
    logic [HANDLE_W-1:0] r_handle, n_handle;
    logic                r_ok, n_ok;
    logic                r_out_valid;
    logic [HANDLE_W-1:0] r_out_handle;
    logic                r_out_ok;
    logic                r_out_zone;

    logic                w_acc;
    logic [FUNC_W-1:0]   w_func;
    logic [ADDR_W-1:0]   w_lo, w_hi, w_addr;
    logic [HANDLE_W-1:0] w_hin;
    logic [XW-1:0]       w_cnt_x, w_hin_x, w_first_x;
    logic                w_add_ok;
    t_cell_ctl           w_ctl;

    logic [ADDR_W-1:0]    w_cell_lo [MAX_AREAS];
    logic [ADDR_W-1:0]    w_cell_hi [MAX_AREAS];
    logic [MAX_AREAS-1:0] w_hit;

    assign w_func = s_axis_tuser;
    assign w_lo   = s_axis_tdata[15:0];
    assign w_hi   = s_axis_tdata[31:16];
    assign w_hin  = s_axis_tdata[35:32];
    assign w_addr = s_axis_tdata[51:36];

    assign s_axis_tready = (r_state == S_IDLE) && (!r_out_valid || m_axis_tready);
    assign w_acc         = s_axis_tvalid && s_axis_tready;

    assign w_cnt_x   = XW'(r_count);
    assign w_hin_x   = XW'(w_hin);
    assign w_first_x = w_hin_x - XW'(1);
    assign w_add_ok  = (w_func == FN_ADD) && (w_cnt_x < N_X);

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_handle = r_handle;
        n_ok     = r_ok;
        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    n_state  = S_EVAL;
                    n_ok     = (w_func == FN_REMOVE) && (w_hin_x != '0) &&
                               (w_hin_x <= w_cnt_x);
                    n_handle = w_add_ok ? HANDLE_W'(w_cnt_x + XW'(1)) : '0;
                    if (w_add_ok) begin
                        n_count = r_count + CW'(1);
                    end else if (n_ok) begin
                        n_count = r_count - CW'(1);
                    end
                end
            end
            S_EVAL: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        w_ctl       = '0;
        w_ctl.act   = w_acc;
        w_ctl.add   = w_add_ok;
        w_ctl.shift = n_ok && w_acc;
        w_ctl.check = (w_func == FN_CHECK);
        w_ctl.count = IDX_W'(r_count);
        w_ctl.first = IDX_W'(w_first_x);
        w_ctl.lo    = w_lo;
        w_ctl.hi    = w_hi;
        w_ctl.addr  = w_addr;
    end

    for (genvar g = 0; g < MAX_AREAS; g++) begin : g_cell
        logic [ADDR_W-1:0] w_nlo, w_nhi;
        if (g + 1 < MAX_AREAS) begin : g_link
            assign w_nlo = w_cell_lo[g+1];
            assign w_nhi = w_cell_hi[g+1];
        end else begin : g_end
            assign w_nlo = '0;
            assign w_nhi = '0;
        end
        prt_cell #(
            .IDX       (g),
            .MAX_AREAS (MAX_AREAS)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (w_ctl),
            .i_nxt_lo (w_nlo),
            .i_nxt_hi (w_nhi),
            .o_lo     (w_cell_lo[g]),
            .o_hi     (w_cell_hi[g]),
            .o_hit    (w_hit[g])
        );
    end

    always_ff @(posedge i_clk) begin
        r_handle <= n_handle;
        r_ok     <= n_ok;
        if (r_state == S_EVAL) begin
            r_out_handle <= r_handle;
            r_out_ok     <= r_ok;
            r_out_zone   <= |w_hit;
        end
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (r_state == S_EVAL) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out_zone, r_out_ok, r_out_handle};

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        XW'(r_count) <= N_X)
        else $error("entry count beyond table size");

    a_acc_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |=> (r_state == S_EVAL) && !r_out_valid)
        else $error("accepted item not evaluated next cycle");

    a_eval_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EVAL) |=> m_axis_tvalid)
        else $error("evaluated item gave no result");

    a_remove_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && n_ok) |=> (r_count == CW'($past(r_count) - CW'(1))))
        else $error("successful remove did not shrink the table");

endmodule

`default_nettype wire

// ----- sim/range_table_checker.sv -----
// ----------------------------------------------------------------------------
// range_table_checker
// watches both streams of the range table, keeps its own copy of the table
// and compares every returned item with the answer worked out on entry
// ----------------------------------------------------------------------------
module range_table_checker #(
    parameter int MAX_AREAS = prt_pkg::MAX_AREAS_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    input  wire         s_axis_tready,
    // range_start, range_end, handle_in, probe_address, zero pad
    input  wire  [55:0] s_axis_tdata,
    // func
    input  wire  [1:0]  s_axis_tuser,
    input  wire         m_axis_tvalid,
    input  wire         m_axis_tready,
    // handle_out, remove_ok, in_zone, zero pad
    input  wire  [7:0]  m_axis_tdata,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_results,
    output int          o_full_adds,
    output int          o_zone_hits
);
    import prt_pkg::*;

    typedef struct {
        logic [FUNC_W-1:0]   func;
        logic [ADDR_W-1:0]   lo;
        logic [ADDR_W-1:0]   hi;
        logic [HANDLE_W-1:0] handle;
        logic [ADDR_W-1:0]   probe;
    } table_op_t;

    typedef struct packed {
        logic                in_zone;
        logic                remove_ok;
        logic [HANDLE_W-1:0] handle;
    } table_answer_t;

    logic [ADDR_W-1:0] zone_lo [MAX_AREAS];
    logic [ADDR_W-1:0] zone_hi [MAX_AREAS];
    int unsigned       zone_count = 0;
    table_answer_t     predicted_answers [$];
    int                fails = 0;
    int                results = 0;
    int                full_adds = 0;
    int                zone_hits = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_results    = 0;
        o_full_adds  = 0;
        o_zone_hits  = 0;
    end

    function automatic table_answer_t predict_answer(table_op_t op);
        table_answer_t ans;
        ans = '0;
        case (op.func)
            FN_ADD: begin
                if (zone_count < MAX_AREAS) begin
                    zone_lo[zone_count] = op.lo;
                    zone_hi[zone_count] = op.hi;
                    zone_count++;
                    ans.handle = HANDLE_W'(zone_count);
                end else begin
                    full_adds++;
                end
            end
            FN_REMOVE: begin
                // later entries close the gap left by the removed one
                if (op.handle != '0 && op.handle <= zone_count) begin
                    zone_count--;
                    for (int k = int'(op.handle) - 1; k < int'(zone_count); k++) begin
                        zone_lo[k] = zone_lo[k + 1];
                        zone_hi[k] = zone_hi[k + 1];
                    end
                    ans.remove_ok = 1'b1;
                end
            end
            FN_CHECK: begin
                for (int k = 0; k < int'(zone_count); k++) begin
                    if (op.probe >= zone_lo[k] && op.probe <= zone_hi[k]) begin
                        ans.in_zone = 1'b1;
                    end
                end
                if (ans.in_zone) begin
                    zone_hits++;
                end
            end
            default: ;
        endcase
        return ans;
    endfunction

    always @(posedge i_clk) begin
        table_op_t     op;
        table_answer_t got;
        table_answer_t want;
        if (!i_rst_n) begin
            zone_count = 0;
            predicted_answers.delete();
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                op.func   = s_axis_tuser;
                op.lo     = s_axis_tdata[15:0];
                op.hi     = s_axis_tdata[31:16];
                op.handle = s_axis_tdata[35:32];
                op.probe  = s_axis_tdata[51:36];
                predicted_answers.push_back(predict_answer(op));
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata[5:0];
                results++;
                if (predicted_answers.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected item, got handle_out %0d remove_ok %0d in_zone %0d",
                             $time, got.handle, got.remove_ok, got.in_zone);
                end else begin
                    want = predicted_answers.pop_front();
                    if (got.handle !== want.handle) begin
                        fails++;
                        $display("%0t: handle_out expected %0d, got %0d",
                                 $time, want.handle, got.handle);
                    end
                    if (got.remove_ok !== want.remove_ok) begin
                        fails++;
                        $display("%0t: remove_ok expected %0d, got %0d",
                                 $time, want.remove_ok, got.remove_ok);
                    end
                    if (got.in_zone !== want.in_zone) begin
                        fails++;
                        $display("%0t: in_zone expected %0d, got %0d",
                                 $time, want.in_zone, got.in_zone);
                    end
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= predicted_answers.size();
        o_results    <= results;
        o_full_adds  <= full_adds;
        o_zone_hits  <= zone_hits;
    end

endmodule

// ----- sim/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// drives add, remove, check and unused-selector items into the range table under changing
// idle patterns and a long output stall, and reports the checker's verdict
// ----------------------------------------------------------------------------
module testbench;
    import prt_pkg::*;

    localparam int                MAX_AREAS   = MAX_AREAS_DEF;
    localparam logic [FUNC_W-1:0] FN_UNUSED   = 2'd3;
    localparam int                STALL_LEN   = 300;
    localparam int                CYCLE_LIMIT = 400000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // range_start, range_end, handle_in, probe_address, zero pad
    logic [55:0] s_axis_tdata = '0;
    // func
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // handle_out, remove_ok, in_zone, zero pad
    logic [7:0]  m_axis_tdata;

    int          fail_count;
    int          pending;
    int          results;
    int          full_adds;
    int          zone_hits;

    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          stall_seq = 0;
    int          stall_seen = 0;
    int          stall_left = 0;
    int          cycles = 0;
    int unsigned n_add = 0;
    int unsigned n_remove = 0;
    int unsigned n_check = 0;
    int unsigned n_unused = 0;

    logic [ADDR_W-1:0] recent_lo [8] = '{default: '0};
    logic [ADDR_W-1:0] recent_hi [8] = '{default: '0};
    int                recent_wr = 0;

    protected_range_table_core #(
        .MAX_AREAS(MAX_AREAS)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    range_table_checker #(
        .MAX_AREAS(MAX_AREAS)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_results    (results),
        .o_full_adds  (full_adds),
        .o_zone_hits  (zone_hits)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d items still outstanding", cycles, pending);
            $display("Verification failed");
            $finish;
        end
    end

    // receiver: random back-pressure, or a long hold-off when one is requested
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else if (stall_seq != stall_seen) begin
            stall_seen = stall_seq;
            stall_left = STALL_LEN - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic offer_item(input logic [FUNC_W-1:0] func, input logic [ADDR_W-1:0] lo,
                              input logic [ADDR_W-1:0] hi, input logic [HANDLE_W-1:0] handle,
                              input logic [ADDR_W-1:0] probe);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) begin
            gap++;
        end
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= func;
        s_axis_tdata  <= {4'b0000, probe, handle, hi, lo};
        do @(posedge i_clk); while (!s_axis_tready);
        case (func)
            FN_ADD:    n_add++;
            FN_REMOVE: n_remove++;
            FN_CHECK:  n_check++;
            default:   n_unused++;
        endcase
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic random_item(input int add_w, input int rem_w);
        logic [FUNC_W-1:0]   func;
        logic [ADDR_W-1:0]   lo;
        logic [ADDR_W-1:0]   hi;
        logic [ADDR_W-1:0]   probe;
        logic [HANDLE_W-1:0] handle;
        int                  pick;
        int                  j;
        int                  top;
        lo     = ADDR_W'($urandom);
        hi     = ADDR_W'($urandom);
        probe  = ADDR_W'($urandom);
        handle = HANDLE_W'($urandom);
        pick   = $urandom_range(99);
        if (pick < add_w) begin
            func = FN_ADD;
            case ($urandom_range(9))
                0, 1, 2, 3, 4, 5: begin
                    top = int'(lo) + $urandom_range(2047);
                    hi  = (top > 65535) ? 16'hFFFF : ADDR_W'(top);
                end
                6, 7: ;
                // start just above end, holds nothing
                8: begin
                    lo = ADDR_W'($urandom_range(65535, 1));
                    hi = lo - 16'd1;
                end
                default: begin
                    lo = $urandom_range(1) ? 16'h0000 : lo;
                    hi = 16'hFFFF;
                end
            endcase
            recent_lo[recent_wr] = lo;
            recent_hi[recent_wr] = hi;
            recent_wr = (recent_wr + 1) % 8;
        end else if (pick < add_w + rem_w) begin
            func = FN_REMOVE;
            if ($urandom_range(99) < 85) begin
                handle = HANDLE_W'($urandom_range(MAX_AREAS, 1));
            end
        end else if (pick < 97) begin
            func = FN_CHECK;
            j = $urandom_range(7);
            case ($urandom_range(5))
                0: probe = recent_lo[j] - 16'd1;
                1: probe = recent_lo[j];
                2: probe = recent_hi[j];
                3: probe = recent_hi[j] + 16'd1;
                4: probe = ADDR_W'((int'(recent_lo[j]) + int'(recent_hi[j])) / 2);
                default: ;
            endcase
        end else begin
            func = FN_UNUSED;
        end
        offer_item(func, lo, hi, handle, probe);
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty table, bad handles, edge ranges, full table
        offer_item(FN_CHECK,  16'h0000, 16'h0000, 4'd0,  16'h0000);
        offer_item(FN_REMOVE, 16'h0000, 16'h0000, 4'd1,  16'h0000);
        offer_item(FN_REMOVE, 16'h0000, 16'h0000, 4'd0,  16'h0000);
        offer_item(FN_ADD,    16'h0000, 16'h0000, 4'd0,  16'h0000);
        offer_item(FN_ADD,    16'hFFFF, 16'hFFFF, 4'd15, 16'hFFFF);
        offer_item(FN_ADD,    16'h1000, 16'h1FFF, 4'd0,  16'h0000);
        offer_item(FN_ADD,    16'h8000, 16'h7FFF, 4'd0,  16'h0000);
        offer_item(FN_CHECK,  16'h0000, 16'h0000, 4'd0,  16'h0000);
        offer_item(FN_CHECK,  16'h0000, 16'h0000, 4'd0,  16'hFFFF);
        offer_item(FN_CHECK,  16'h0000, 16'h0000, 4'd0,  16'h7FFF);
        offer_item(FN_CHECK,  16'h0000, 16'h0000, 4'd0,  16'h1000);
        offer_item(FN_CHECK,  16'h0000, 16'h0000, 4'd0,  16'h2000);
        for (int i = 0; i < 4; i++) begin
            offer_item(FN_ADD, 16'h3000 + 16'(i * 256), 16'h30FF + 16'(i * 256), 4'd0, 16'h0000);
        end
        offer_item(FN_ADD,    16'hFFFF, 16'hFFFF, 4'd0,  16'h0000);
        offer_item(FN_REMOVE, 16'h0000, 16'h0000, 4'd9,  16'h0000);
        offer_item(FN_REMOVE, 16'h0000, 16'h0000, 4'd15, 16'h0000);
        offer_item(FN_REMOVE, 16'h0000, 16'h0000, 4'd0,  16'h0000);
        offer_item(FN_REMOVE, 16'h0000, 16'h0000, 4'd1,  16'h0000);
        offer_item(FN_REMOVE, 16'h0000, 16'h0000, 4'd7,  16'h0000);
        offer_item(FN_UNUSED, 16'hFFFF, 16'hFFFF, 4'd15, 16'hFFFF);
        offer_item(FN_CHECK,  16'h0000, 16'h0000, 4'd0,  16'h0000);
        wait_drained();

        // output held off while items keep coming
        stall_seq <= stall_seq + 1;
        repeat (40) random_item(50, 10);
        wait_drained();

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 14 : (phase == 1) ? 79 : 0;
            recv_idle_pct <= (phase == 0) ? 79 : (phase == 1) ? 14 : 0;
            for (int blk = 0; blk < 10; blk++) begin
                automatic int add_w = $urandom_range(60, 15);
                automatic int rem_w = $urandom_range(30, 10);
                repeat (50) random_item(add_w, rem_w);
            end
            wait_drained();
        end

        repeat (8) @(posedge i_clk);
        $display("covered %0d items: %0d add, %0d remove, %0d check, %0d unused selector",
                 n_add + n_remove + n_check + n_unused, n_add, n_remove, n_check, n_unused);
        $display("%0d results compared, %0d adds on a full table, %0d probes inside a range",
                 results, full_adds, zone_hits);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/prt_pkg.sv
hdl/prt_cell.sv
hdl/protected_range_table_core.sv
sim/range_table_checker.sv
sim/testbench.sv
